>>> design/skc_pkg.sv
// Shared constants, register indexes and multiplier types for the soft-knee compressor.
`timescale 1ns / 1ps
package skc_pkg;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 30;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef logic signed [MUL_A_W-1:0] mul_a_t;
	typedef logic signed [MUL_B_W-1:0] mul_b_t;
	typedef logic signed [MUL_P_W-1:0] mul_p_t;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAKEUP     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RMS_DETECT = 4'd7;

	// dB conversion constants
	localparam int DB_FLOOR      = -25600;
	localparam int DB_PER_OCT    = 394566;
	localparam int OCT_PER_DB    = 10885;
	localparam int EXP_POLY_INIT = 5139;
	localparam int UNITY_Q16     = 65536;

	// Horner coefficients of the 2^f mantissa polynomial, applied after each product
	function automatic logic [16:0] horner_coeff(input logic [1:0] step);
		logic [16:0] c;
		case (step)
			2'd0:    c = 17'd14791;
			2'd1:    c = 17'd45606;
			default: c = 17'd65536;
		endcase
		return c;
	endfunction

endpackage

>>> design/skc_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module skc_mul (
	input  logic            clk,
	input  skc_pkg::mul_a_t op_a,
	input  skc_pkg::mul_b_t op_b,
	output skc_pkg::mul_p_t prod_q
);
	import skc_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
	end

endmodule

>>> design/soft_knee_compressor_top.sv
// Top level of the soft-knee feed-forward compressor: sequencer, state and config registers.
`timescale 1ns / 1ps
// Sequence: a peak-detected sample on the hard knee takes one normalization step per leading
//   zero of the level, then the log, dB, curve, ballistics, gain and mix steps; a silent sample
//   skips the log and dB steps. RMS detection adds six multiply-accumulate steps and a 24-step
//   root, the soft knee adds a 26-step divide. The sequencer runs one item at a time through a
//   single registered multiplier; a result held by m_tready stalls the next accept.
// Reset (arst_n low, asynchronous): registers take their documented defaults, detector
//   and gain state of every channel clear to zero, no result pending.
module soft_knee_compressor_top #(
	parameter int CHANNELS  = 2,
	parameter int RMS_COEFF = 65263
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,   // [23:0] sample_in
	input  logic [0:0]                      s_tuser,   // [0] channel
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [23:0]                     m_tdata,   // [23:0] sample_out
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [skc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [skc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import skc_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [MUL_B_W-1:0] RC_B  = MUL_B_W'(RMS_COEFF);
	localparam logic [MUL_B_W-1:0] RC2_B = MUL_B_W'(UNITY_Q16 - RMS_COEFF);

	typedef enum logic [5:0] {
		S_IDLE, S_R_SQ, S_R_M0, S_R_M1, S_R_M2, S_R_M3, S_R_M4, S_SQRT,
		S_NORM, S_LOG_SQ, S_LOG_UP, S_DB_MUL, S_DB_GET, S_CURVE, S_CSEL,
		S_C_LIN, S_C_T2, S_C_T2SQ, S_C_NUM, S_DIV, S_DIV_END, S_BAL, S_BAL_GET,
		S_EXP, S_EXP_GET, S_H_MUL, S_H_GET, S_WET_MUL, S_WET_SH,
		S_MIX1, S_MIX2, S_MIX3, S_DONE
	} state_t;

	// configuration registers
	logic signed [14:0] thr_q;
	logic signed [16:0] slope_q;
	logic        [12:0] knee_q;
	logic        [15:0] atk_q;
	logic        [15:0] rel_q;
	logic signed [13:0] makeup_q;
	logic        [16:0] wet_mix_q;
	logic               rms_q;

	// per-channel state
	logic        [47:0] ms_q [CHANNELS];
	logic signed [15:0] gr_q [CHANNELS];

	// sequencer and datapath registers
	state_t             state_q;
	logic               m_tvalid_q;
	logic        [23:0] m_tdata_q;
	logic        [CH_W-1:0] ch_q;
	logic signed [23:0] x_q;
	logic        [23:0] ax_q;
	logic        [23:0] lvl_q;       // detector level, then log mantissa
	logic        [47:0] sq_q;
	logic        [63:0] acc_q;
	logic        [47:0] v_q;         // root radicand, then divide dividend (top bits)
	logic        [26:0] rem_q;
	logic        [23:0] root_q;
	logic        [25:0] quo_q;
	logic               dneg_q;
	logic        [4:0]  cnt_q;
	logic signed [5:0]  exp_q;
	logic        [11:0] frac_q;
	logic signed [16:0] db_q;
	logic signed [17:0] d_q;
	logic        [14:0] t2_q;
	logic signed [15:0] tgt_q;
	logic signed [15:0] g_q;
	logic signed [7:0]  n_q;
	logic        [15:0] f_q;
	logic        [16:0] t_q;
	logic signed [23:0] wet_q;
	logic signed [40:0] mix_q;
	logic signed [23:0] res_q;

	mul_a_t op_a;
	mul_b_t op_b;
	mul_p_t prod_q;

	skc_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767)
			return 16'sh7FFF;
		if (v < -40'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		if (v > 26'sd8388607)
			return 24'sh7FFFFF;
		if (v < -26'sd8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// clamp wet mix to unity
	logic [16:0] wmix;
	assign wmix = (wet_mix_q > 17'd65536) ? 17'd65536 : wet_mix_q;

	// current channel state
	logic        [47:0] ms_cur;
	logic signed [15:0] g_cur;
	logic        [15:0] bal_coef;
	assign ms_cur   = ms_q[ch_q];
	assign g_cur    = gr_q[ch_q];
	assign bal_coef = (tgt_q < g_cur) ? atk_q : rel_q;

	// combinational helpers
	logic        [26:0] sq_rem;
	logic        [25:0] sq_trial;
	logic signed [18:0] d2;
	logic signed [18:0] kk;
	logic        [14:0] dv_rem;
	logic        [63:0] rms_sum;
	logic signed [34:0] dbw;
	logic signed [35:0] num_sh;
	logic signed [39:0] quo_s;
	logic signed [39:0] div_res;
	logic signed [17:0] bal_diff;
	logic signed [17:0] gm;
	logic        [17:0] h_sum;
	logic signed [41:0] mix_sum;
	logic signed [7:0]  n_cl;
	logic signed [8:0]  rsh;
	logic        [48:0] mag;
	logic signed [23:0] wet_nxt;

	assign sq_rem   = {rem_q[24:0], v_q[47:46]};
	assign sq_trial = {root_q, 2'b01};
	assign d2       = 19'(d_q) <<< 1;
	assign kk       = $signed({6'b0, knee_q});
	assign dv_rem   = {rem_q[13:0], v_q[47]};
	assign rms_sum  = acc_q + {prod_q[39:0], 24'b0};
	assign dbw      = $signed(prod_q[54:20]);
	assign num_sh   = $signed(prod_q[54:19]);
	assign quo_s    = $signed({14'b0, quo_q});
	assign div_res  = dneg_q ? (-quo_s - 40'(rem_q != 27'd0)) : quo_s;
	assign bal_diff = 18'(g_cur) - 18'(tgt_q);
	assign gm       = 18'(g_q) + 18'(makeup_q);
	assign h_sum    = {1'b0, prod_q[32:16]} + {1'b0, horner_coeff(cnt_q[1:0])};
	assign mix_sum  = 42'(mix_q) + 42'($signed(prod_q[40:0]));

	// scale |x|*m by 2^(n-16), then apply sign and saturate
	always_comb begin
		n_cl = (n_q > 8'sd24) ? 8'sd24 : n_q;
		rsh  = 9'sd16 - 9'(n_cl);
		if (n_cl >= 8'sd16)
			mag = {8'b0, prod_q[40:0]} << 4'(n_cl - 8'sd16);
		else if (rsh >= 9'sd49)
			mag = '0;
		else
			mag = {8'b0, prod_q[40:0]} >> rsh[5:0];
		if (x_q[23])
			wet_nxt = (mag >= 49'd8388608) ? 24'sh800000 : $signed(~mag[23:0] + 24'd1);
		else
			wet_nxt = (mag >= 49'd8388607) ? 24'sh7FFFFF : $signed(mag[23:0]);
	end

	// multiplier operand select per sequencer step
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_R_SQ:    begin op_a = {1'b0, ax_q};          op_b = {6'b0, ax_q};       end
			S_R_M0:    begin op_a = {1'b0, ms_cur[23:0]};  op_b = RC_B;               end
			S_R_M1:    begin op_a = {1'b0, ms_cur[47:24]}; op_b = RC_B;               end
			S_R_M2:    begin op_a = {1'b0, sq_q[23:0]};    op_b = RC2_B;              end
			S_R_M3:    begin op_a = {1'b0, sq_q[47:24]};   op_b = RC2_B;              end
			S_LOG_SQ:  begin op_a = {1'b0, lvl_q};         op_b = {6'b0, lvl_q};      end
			S_DB_MUL:  begin
				op_a = MUL_A_W'($signed({exp_q, frac_q}));
				op_b = MUL_B_W'(DB_PER_OCT);
			end
			S_CSEL:    begin op_a = MUL_A_W'(slope_q);     op_b = MUL_B_W'(d_q);      end
			S_C_T2:    begin op_a = {10'b0, t2_q};         op_b = {15'b0, t2_q};      end
			S_C_T2SQ:  begin op_a = MUL_A_W'(slope_q);     op_b = prod_q[29:0];       end
			S_BAL:     begin op_a = MUL_A_W'(bal_diff);    op_b = {14'b0, bal_coef};  end
			S_EXP:     begin op_a = MUL_A_W'(gm);          op_b = MUL_B_W'(OCT_PER_DB); end
			S_H_MUL:   begin op_a = {8'b0, t_q};           op_b = {14'b0, f_q};       end
			S_WET_MUL: begin op_a = {1'b0, ax_q};          op_b = {13'b0, t_q};       end
			S_MIX1:    begin op_a = MUL_A_W'(wet_q);       op_b = {13'b0, wmix};      end
			S_MIX2:    begin
				op_a = MUL_A_W'(x_q);
				op_b = {13'b0, 17'(17'd65536 - wmix)};
			end
			default:   begin op_a = '0;                    op_b = '0;                 end
		endcase
	end

	// configuration registers; writes beyond the list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= -15'sd5120;
			slope_q   <= -17'sd49152;
			knee_q    <= '0;
			atk_q     <= 16'd65000;
			rel_q     <= 16'd65500;
			makeup_q  <= '0;
			wet_mix_q <= 17'd65536;
			rms_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESHOLD:  thr_q     <= cfg_data[14:0];
				REG_SLOPE:      slope_q   <= cfg_data[16:0];
				REG_KNEE:       knee_q    <= cfg_data[12:0];
				REG_ATTACK:     atk_q     <= cfg_data[15:0];
				REG_RELEASE:    rel_q     <= cfg_data[15:0];
				REG_MAKEUP:     makeup_q  <= cfg_data[13:0];
				REG_WET_MIX:    wet_mix_q <= cfg_data[16:0];
				REG_RMS_DETECT: rms_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer: state, channel state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				ms_q[i] <= '0;
				gr_q[i] <= '0;
			end
		end else begin
			// raise the result once the output register is free, drop it once it is taken
			if (state_q == S_DONE && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						x_q   <= s_tdata;
						ax_q  <= s_tdata[23] ? 24'(-$signed(s_tdata)) : s_tdata;
						lvl_q <= s_tdata[23] ? 24'(-$signed(s_tdata)) : s_tdata;
						ch_q  <= (CHANNELS > 1) ? CH_W'(s_tuser[0]) : '0;
						exp_q <= '0;
						state_q <= rms_q ? S_R_SQ : S_NORM;
					end
				end
				// RMS detector: ms = (C*ms + (1-C)*x^2) >> 16, in 24-bit halves
				S_R_SQ: state_q <= S_R_M0;
				S_R_M0: begin
					sq_q    <= prod_q[47:0];
					state_q <= S_R_M1;
				end
				S_R_M1: begin
					acc_q   <= {24'b0, prod_q[39:0]};
					state_q <= S_R_M2;
				end
				S_R_M2: begin
					acc_q   <= rms_sum;
					state_q <= S_R_M3;
				end
				S_R_M3: begin
					acc_q   <= acc_q + {24'b0, prod_q[39:0]};
					state_q <= S_R_M4;
				end
				S_R_M4: begin
					ms_q[ch_q] <= rms_sum[63:16];
					v_q        <= rms_sum[63:16];
					rem_q      <= '0;
					root_q     <= '0;
					cnt_q      <= 5'd23;
					state_q    <= S_SQRT;
				end
				// digit-by-digit root, one result bit per cycle
				S_SQRT: begin
					v_q <= {v_q[45:0], 2'b00};
					if (sq_rem >= {1'b0, sq_trial}) begin
						rem_q  <= sq_rem - {1'b0, sq_trial};
						root_q <= {root_q[22:0], 1'b1};
					end else begin
						rem_q  <= sq_rem;
						root_q <= {root_q[22:0], 1'b0};
					end
					if (cnt_q == 5'd0) begin
						lvl_q   <= (sq_rem >= {1'b0, sq_trial}) ? {root_q[22:0], 1'b1}
						                                        : {root_q[22:0], 1'b0};
						state_q <= S_NORM;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				// normalize one bit per cycle
				S_NORM: begin
					if (lvl_q == 24'd0) begin
						db_q    <= 17'(DB_FLOOR);
						state_q <= S_CURVE;
					end else if (lvl_q[23]) begin
						frac_q  <= '0;
						cnt_q   <= 5'd11;
						state_q <= S_LOG_SQ;
					end else begin
						lvl_q <= {lvl_q[22:0], 1'b0};
						exp_q <= exp_q - 6'sd1;
					end
				end
				// log2 fraction by repeated squaring
				S_LOG_SQ: state_q <= S_LOG_UP;
				S_LOG_UP: begin
					if (prod_q[47]) begin
						frac_q[cnt_q[3:0]] <= 1'b1;
						lvl_q <= prod_q[47:24];
					end else begin
						lvl_q <= prod_q[46:23];
					end
					if (cnt_q == 5'd0) begin
						state_q <= S_DB_MUL;
					end else begin
						cnt_q   <= cnt_q - 5'd1;
						state_q <= S_LOG_SQ;
					end
				end
				S_DB_MUL: state_q <= S_DB_GET;
				S_DB_GET: begin
					db_q    <= (dbw < 35'(DB_FLOOR)) ? 17'(DB_FLOOR) : dbw[16:0];
					state_q <= S_CURVE;
				end
				// static curve
				S_CURVE: begin
					d_q     <= 18'(db_q) - 18'(thr_q);
					state_q <= S_CSEL;
				end
				S_CSEL: begin
					if (knee_q == 13'd0) begin
						if (d_q > 18'sd0) begin
							state_q <= S_C_LIN;
						end else begin
							tgt_q   <= '0;
							state_q <= S_BAL;
						end
					end else if (d2 < -kk) begin
						tgt_q   <= '0;
						state_q <= S_BAL;
					end else if (d2 <= kk) begin
						t2_q    <= 15'(d2 + kk);
						state_q <= S_C_T2;
					end else begin
						state_q <= S_C_LIN;
					end
				end
				S_C_LIN: begin
					tgt_q   <= sat16(40'($signed(prod_q[54:16])));
					state_q <= S_BAL;
				end
				S_C_T2:   state_q <= S_C_T2SQ;
				S_C_T2SQ: state_q <= S_C_NUM;
				// floor(num / (k * 2^19)) = floor(floor(num / 2^19) / k)
				S_C_NUM: begin
					dneg_q  <= num_sh[35];
					v_q     <= {(num_sh[35] ? 26'(-num_sh) : 26'(num_sh)), 22'b0};
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= 5'd25;
					state_q <= S_DIV;
				end
				S_DIV: begin
					v_q <= {v_q[46:0], 1'b0};
					if (dv_rem >= {2'b0, knee_q}) begin
						rem_q <= {12'b0, 15'(dv_rem - {2'b0, knee_q})};
						quo_q <= {quo_q[24:0], 1'b1};
					end else begin
						rem_q <= {12'b0, dv_rem};
						quo_q <= {quo_q[24:0], 1'b0};
					end
					if (cnt_q == 5'd0)
						state_q <= S_DIV_END;
					else
						cnt_q <= cnt_q - 5'd1;
				end
				S_DIV_END: begin
					tgt_q   <= sat16(div_res);
					state_q <= S_BAL;
				end
				// attack/release ballistics
				S_BAL: state_q <= S_BAL_GET;
				S_BAL_GET: begin
					g_q        <= sat16(40'(tgt_q) + 40'($signed(prod_q[54:16])));
					gr_q[ch_q] <= sat16(40'(tgt_q) + 40'($signed(prod_q[54:16])));
					state_q    <= S_EXP;
				end
				// gain dB to log2 Q16, split into octave and fraction
				S_EXP: state_q <= S_EXP_GET;
				S_EXP_GET: begin
					n_q     <= prod_q[31:24];
					f_q     <= prod_q[23:8];
					t_q     <= 17'(EXP_POLY_INIT);
					cnt_q   <= '0;
					state_q <= S_H_MUL;
				end
				S_H_MUL: state_q <= S_H_GET;
				S_H_GET: begin
					t_q <= h_sum[16:0];
					if (cnt_q == 5'd2) begin
						state_q <= S_WET_MUL;
					end else begin
						cnt_q   <= cnt_q + 5'd1;
						state_q <= S_H_MUL;
					end
				end
				S_WET_MUL: state_q <= S_WET_SH;
				S_WET_SH: begin
					wet_q   <= wet_nxt;
					state_q <= S_MIX1;
				end
				// dry/wet mix
				S_MIX1: state_q <= S_MIX2;
				S_MIX2: begin
					mix_q   <= $signed(prod_q[40:0]);
					state_q <= S_MIX3;
				end
				S_MIX3: begin
					res_q   <= sat24(mix_sum[41:16]);
					state_q <= S_DONE;
				end
				// hold until the output register is free
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= res_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/skc_checker.sv
// Port-level checks for the soft-knee compressor, bound to its top level.
`timescale 1ns / 1ps
module skc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	import skc_pkg::*;

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous item in flight");

	// the input is still busy later in the sequence after an accept
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##3 !s_tready)
		else $error("item finished too quickly");

	// a pending result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pending result dropped or changed");

	// config writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind soft_knee_compressor_top skc_checker u_skc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

>>> dv/testbench.sv
// Self-checking testbench for the soft-knee compressor: stimulus, prediction and scoreboard.
`timescale 1ns / 1ps
module testbench;
	import skc_pkg::*;

	localparam int NUM_CH    = 2;
	localparam int RMS_K     = 65263;
	localparam int SAT_HI    = 8388607;
	localparam int SAT_LO    = -8388608;
	localparam int STALL_MAX = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Sender and receiver idle rates, in percent.
	int send_idle_pct = 9;
	int recv_idle_pct = 68;
	int quiet_cycles = 0;
	int items_sent = 0;
	int configs_done = 0;

	always #10 clk = ~clk;

	soft_knee_compressor_top #(.CHANNELS(NUM_CH), .RMS_COEFF(RMS_K)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor of the compressor with its own register and channel state.
	class gain_scoreboard;
		longint thr, slope, knee, atk, rel, makeup, wet_w, rms_on;
		longint unsigned msq[NUM_CH];
		longint gr[NUM_CH];
		logic [23:0] pending_out[$];
		int mismatches;
		int checked;

		function void reset_state();
			thr = -5120; slope = -49152; knee = 0; atk = 65000; rel = 65500;
			makeup = 0; wet_w = 65536; rms_on = 0;
			foreach (msq[i]) begin
				msq[i] = 0;
				gr[i] = 0;
			end
		endfunction

		function longint sx(longint unsigned v, int w);
			longint unsigned m;
			m = (64'd1 << w) - 1;
			v &= m;
			return v[w-1] ? -longint'(m - v) - 1 : longint'(v);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_THRESHOLD:  thr = sx(val, 15);
				REG_SLOPE:      slope = sx(val, 17);
				REG_KNEE:       knee = val & 17'h1FFF;
				REG_ATTACK:     atk = val & 17'hFFFF;
				REG_RELEASE:    rel = val & 17'hFFFF;
				REG_MAKEUP:     makeup = sx(val, 14);
				REG_WET_MIX:    wet_w = val;
				REG_RMS_DETECT: rms_on = val & 1;
				default: ;
			endcase
		endfunction

		function longint clampv(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint unsigned root_of(longint unsigned v);
			longint unsigned r, t;
			r = 0;
			for (int b = 23; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v) r = t;
			end
			return r;
		endfunction

		function longint level_db(longint unsigned lvl);
			int p;
			longint unsigned m;
			longint l2, db;
			if (lvl == 0) return DB_FLOOR;
			p = 23;
			while (p > 0 && lvl[p] == 1'b0) p--;
			m = lvl << (23 - p);
			l2 = longint'(p - 23) * 4096;
			for (int i = 11; i >= 0; i--) begin
				m = (m * m) >> 23;
				if (m >= (64'd1 << 24)) begin
					l2 += longint'(1) << i;
					m >>= 1;
				end
			end
			db = (l2 * DB_PER_OCT) >>> 20;
			return db < DB_FLOOR ? DB_FLOOR : db;
		endfunction

		function longint knee_curve(longint d);
			longint t2, num, den, q;
			if (knee == 0) return d > 0 ? (slope * d) >>> 16 : 0;
			if (2 * d < -knee) return 0;
			if (2 * d <= knee) begin
				t2 = 2 * d + knee;
				num = slope * t2 * t2;
				den = 8 * knee * 65536;
				q = num / den;
				if (num % den != 0 && num < 0) q -= 1;
				return q;
			end
			return (slope * d) >>> 16;
		endfunction

		// Note an accepted sample and queue the output it must produce.
		function void note_sample(logic [23:0] smp, logic [0:0] chan);
			longint x, tgt, g, e, n, wet, o, w, sh;
			longint unsigned ax, lvl, t, f, m, prod, mag, c;
			int ch;
			x = sx(smp, 24);
			ch = chan % NUM_CH;
			ax = x < 0 ? -x : x;
			if (rms_on != 0) begin
				msq[ch] = ((64'(RMS_K) * msq[ch] + 64'(65536 - RMS_K) * (ax * ax)) >> 16)
					& 64'hFFFF_FFFF_FFFF;
				lvl = root_of(msq[ch]);
			end else begin
				lvl = ax;
			end
			tgt = clampv(knee_curve(level_db(lvl) - thr), -32768, 32767);
			g = gr[ch];
			c = tgt < g ? atk : rel;
			g = clampv(tgt + ((longint'(c) * (g - tgt)) >>> 16), -32768, 32767);
			gr[ch] = g;
			e = ((g + makeup) * OCT_PER_DB) >>> 8;
			n = e >>> 16;
			f = e & 16'hFFFF;
			t = EXP_POLY_INIT;
			t = ((t * f) >> 16) + 14791;
			t = ((t * f) >> 16) + 45606;
			m = UNITY_Q16 + ((t * f) >> 16);
			prod = ax * m;
			if (n > 24) n = 24;
			if (n >= 16) begin
				mag = prod << (n - 16);
			end else begin
				sh = 16 - n;
				mag = sh >= 64 ? 0 : prod >> sh;
			end
			if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
			wet = x < 0 ? -longint'(mag) : longint'(mag);
			wet = clampv(wet, SAT_LO, SAT_HI);
			w = wet_w > 65536 ? 65536 : wet_w;
			o = clampv((wet * w + x * (65536 - w)) >>> 16, SAT_LO, SAT_HI);
			pending_out.push_back(o[23:0]);
		endfunction

		// Compare an accepted output against the oldest queued one.
		function void check_output(logic [23:0] got);
			logic [23:0] want;
			checked++;
			if (pending_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: unexpected output %0d", $signed(got));
				return;
			end
			want = pending_out.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: sample_out expected %0d got %0d", $signed(want),
						$signed(got));
			end
		endfunction
	endclass

	gain_scoreboard sb = new();

	// Receiver: accept outputs, stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_output(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog on cycles without any accepted item or write.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_MAX) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Leave tvalid up after the accept so the next item can follow; drain lowers it.
	task automatic send_sample(logic [23:0] smp, logic [0:0] chan);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= chan;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(smp, chan);
		items_sent++;
	endtask

	// Hold until every queued output has drained, then let the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_out.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		configs_done++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(longint th, longint sl, longint kn, longint at, longint rl,
			longint mk, longint wm, longint rm);
		write_cfg(REG_THRESHOLD, th[16:0]);
		write_cfg(REG_SLOPE, sl[16:0]);
		write_cfg(REG_KNEE, kn[16:0]);
		write_cfg(REG_ATTACK, at[16:0]);
		write_cfg(REG_RELEASE, rl[16:0]);
		write_cfg(REG_MAKEUP, mk[16:0]);
		write_cfg(REG_WET_MIX, wm[16:0]);
		write_cfg(REG_RMS_DETECT, rm[16:0]);
	endtask

	// Mostly musical levels, with full-scale and near-silent samples mixed in.
	task automatic random_burst(int count);
		logic [23:0] smp;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: smp = 24'($urandom);
				1: smp = 24'($signed($urandom_range(2000)) - 1000);
				2: smp = 24'(($urandom_range(1) ? SAT_HI : SAT_LO) + $urandom_range(3));
				default: smp = 24'($signed($urandom_range(4000000)) - 2000000);
			endcase
			send_sample(smp, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		sb.reset_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, both channels, silence, default registers.
		send_sample(24'h7FFFFF, 1'b0);
		send_sample(24'h800000, 1'b1);
		send_sample(24'h000000, 1'b0);
		send_sample(24'h000001, 1'b1);
		send_sample(24'hFFFFFF, 1'b0);
		send_sample(24'h555555, 1'b1);
		send_sample(24'hAAAAAA, 1'b0);
		drain();
		// Soft knee, RMS detection, zero slope and large makeup to saturate.
		write_all(0, 0, 6144, 0, 65535, 6144, 65536, 1);
		write_cfg(4'hF, 17'h1FFFF); // unmapped index, must be ignored
		send_sample(24'h7FFFFF, 1'b0);
		send_sample(24'h400000, 1'b0);
		send_sample(24'h800000, 1'b1);
		send_sample(24'h000010, 1'b1);
		drain();
		write_all(-15360, -62259, 1, 65535, 0, -6144, 0, 0);
		send_sample(24'h123456, 1'b0);
		send_sample(24'hF00000, 1'b1);
		drain();
		write_all(-15360, 30000, 512, 100, 200, 6144, 131071, 1);
		send_sample(24'h7FFFFF, 1'b0);
		send_sample(24'h800001, 1'b1);
		send_sample(24'h000100, 1'b0);
		drain();

		// Random phases under the three idling patterns.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 9 : (ph == 1 ? 68 : 0);
			recv_idle_pct = ph == 0 ? 68 : (ph == 1 ? 9 : 0);
			for (int k = 0; k < 4; k++) begin
				write_all(-$signed($urandom_range(15360)), -$signed($urandom_range(62259)),
					$urandom_range(3) == 0 ? 0 : $urandom_range(6144),
					$urandom_range(65535), $urandom_range(65535),
					$signed($urandom_range(12288)) - 6144,
					$urandom_range(1) ? 65536 : $urandom_range(65536),
					$urandom_range(1));
				random_burst(33);
				drain();
			end
		end

		$display("Run covered %0d samples and %0d register writes over both channels,",
			items_sent, configs_done);
		$display("peak and RMS detection, hard and soft knee, and %0d checked outputs.",
			sb.checked);
		if (sb.mismatches == 0 && sb.pending_out.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

>>> soft_knee_compressor_top.f
design/skc_pkg.sv
design/skc_mul.sv
design/soft_knee_compressor_top.sv
design/skc_checker.sv
dv/testbench.sv
